/* src/eoqs_pkg.sv */
// ----------------------------------------------------------------------------
// eoqs_pkg
// Shared types, codes and the order grouping function of the elevator order
// queue sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package eoqs_pkg;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_DEL = 2'd1;
   localparam logic [1:0] OP_CLR = 2'd2;

   localparam logic [1:0] KIND_UP   = 2'd0;
   localparam logic [1:0] KIND_DOWN = 2'd1;
   localparam logic [1:0] KIND_CAB  = 2'd2;

   localparam logic [1:0] DIR_UP   = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;

   localparam logic [2:0] GRP_UP    = 3'd0;
   localparam logic [2:0] GRP_DOWN  = 3'd1;
   localparam logic [2:0] GRP_SUP   = 3'd2;
   localparam logic [2:0] GRP_SDOWN = 3'd3;
   localparam logic [2:0] GRP_NONE  = 3'd4;

   typedef struct packed {
      logic       valid;
      logic [3:0] floor;
      logic [1:0] kind;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic scan;
      logic seg_start;
      logic next_seg;
      logic row_start;
      logic cmp;
      logic swap;
      logic copy;
      logic dump_next;
   } cmd_type;

   typedef struct packed {
      logic regroup;
      logic is_add;
      logic scan_last;
      logic row_done;
      logic seg_last;
      logic cmp_last;
      logic dump_last;
   } status_type;

   function automatic logic [2:0] classify(input logic [3:0] fl, input logic [1:0] k,
                                           input logic [3:0] cf, input logic [1:0] dir,
                                           input logic at, input logic rel);
      logic [2:0] g;
      g = GRP_NONE;
      if (dir == DIR_UP) begin
         if (at) begin
            if (fl >= cf && (k == KIND_UP || k == KIND_CAB)) g = GRP_UP;
            else if (k == KIND_DOWN || (fl < cf && k == KIND_CAB)) g = GRP_DOWN;
            else if (fl < cf && k == KIND_UP) g = GRP_SUP;
         end else begin
            if (fl > cf && (k == KIND_UP || k == KIND_CAB)) g = GRP_UP;
            else if (k == KIND_DOWN || (fl <= cf && k == KIND_CAB)) g = GRP_DOWN;
            else if (fl <= cf && k == KIND_UP) g = (!rel && fl == cf) ? GRP_UP : GRP_SUP;
         end
      end else if (dir == DIR_DOWN) begin
         if (at) begin
            if (fl <= cf && (k == KIND_DOWN || k == KIND_CAB)) g = GRP_DOWN;
            else if (k == KIND_UP || (fl > cf && k == KIND_CAB)) g = GRP_UP;
            else if (fl > cf && k == KIND_DOWN) g = GRP_SDOWN;
         end else begin
            if (fl < cf && (k == KIND_DOWN || k == KIND_CAB)) g = GRP_DOWN;
            else if (k == KIND_UP || (fl >= cf && k == KIND_CAB)) g = GRP_UP;
            else if (fl >= cf && k == KIND_DOWN) g = (rel && fl == cf) ? GRP_DOWN : GRP_SDOWN;
         end
      end
      return g;
   endfunction

endpackage

`default_nettype wire

/* src/eoqs_dpath.sv */
// ----------------------------------------------------------------------------
// eoqs_dpath
// Queue storage, group buffer, scan and selection sort counters, and the
// queue dump read port.
// ----------------------------------------------------------------------------
`default_nettype none

module eoqs_dpath #(
   parameter int DEPTH = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire eoqs_pkg::cmd_type   cmd,
   output eoqs_pkg::status_type     status,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [3:0]          req_slot_index,
   input  wire logic [3:0]          req_order_floor,
   input  wire logic [1:0]          req_order_kind,
   input  wire logic [3:0]          req_car_floor,
   input  wire logic [1:0]          req_direction,
   input  wire logic                req_at_floor,
   input  wire logic                req_relative_position,
   output logic [3:0]               rsp_slot,
   output logic                     rsp_entry_valid,
   output logic [3:0]               rsp_entry_floor,
   output logic [1:0]               rsp_entry_kind,
   output logic                     rsp_last_slot
);
   import eoqs_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         q_ff [DEPTH];
   entry_type         q_in [DEPTH];
   entry_type         buf_ff [DEPTH];
   entry_type         buf_in [DEPTH];
   logic [CW-1:0]     end_ff [4];
   logic [CW-1:0]     end_in [4];
   logic [1:0]        op_ff, op_in;
   logic [3:0]        idx_ff, idx_in;
   entry_type         new_ff, new_in;
   logic [3:0]        cf_ff, cf_in;
   logic [1:0]        dir_ff, dir_in;
   logic              at_ff, at_in;
   logic              rel_ff, rel_in;
   logic [1:0]        seg_ff, seg_in;
   logic [IW-1:0]     sc_ff, sc_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [IW-1:0]     pick_ff, pick_in;
   entry_type         best_ff, best_in;
   logic [IW-1:0]     cnt_ff, cnt_in;

   entry_type         scan_e;
   entry_type         cand;
   logic              hit;
   logic [CW-1:0]     pos_nx;
   logic [CW-1:0]     lo, hi;
   logic              asc;
   logic              better;
   logic              del_ok;
   entry_type         rd;

   always_comb begin
      scan_e = q_ff[sc_ff];
      hit    = scan_e.valid && (classify(scan_e.floor, scan_e.kind, cf_ff, dir_ff, at_ff,
                                         rel_ff) == {1'b0, seg_ff[1], seg_ff[0] ^ dir_ff[0]});
      pos_nx = pos_ff + CW'(hit);
      lo     = (seg_ff == 2'd0) ? '0 : end_ff[seg_ff - 2'd1];
      hi     = end_ff[seg_ff];
      asc    = !(seg_ff[0] ^ dir_ff[0]);
      cand   = buf_ff[j_ff[IW-1:0]];
      better = asc ? (cand.floor < best_ff.floor) : (cand.floor > best_ff.floor);
      del_ok = {2'b00, idx_ff} < 6'(DEPTH);
   end

   always_comb begin
      q_in    = q_ff;
      buf_in  = buf_ff;
      end_in  = end_ff;
      op_in   = op_ff;
      idx_in  = idx_ff;
      new_in  = new_ff;
      cf_in   = cf_ff;
      dir_in  = dir_ff;
      at_in   = at_ff;
      rel_in  = rel_ff;
      seg_in  = seg_ff;
      sc_in   = sc_ff;
      pos_in  = pos_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      pick_in = pick_ff;
      best_in = best_ff;
      cnt_in  = cnt_ff;
      if (cmd.capture) begin
         op_in  = req_opcode;
         idx_in = req_slot_index;
         new_in = '{valid: 1'b1, floor: req_order_floor, kind: req_order_kind};
         cf_in  = req_car_floor;
         dir_in = req_direction;
         at_in  = req_at_floor;
         rel_in = req_relative_position;
      end
      if (cmd.apply) begin
         seg_in = '0;
         sc_in  = '0;
         pos_in = '0;
         cnt_in = '0;
         case (op_ff)
            OP_ADD: q_in[DEPTH-1] = new_ff;
            OP_DEL: begin
               if (del_ok) begin
                  for (int k = 0; k < DEPTH - 1; k++) begin
                     if (6'(k) >= {2'b00, idx_ff}) q_in[k] = q_ff[k+1];
                  end
                  q_in[DEPTH-1] = '0;
               end
            end
            OP_CLR: begin
               for (int k = 0; k < DEPTH; k++) q_in[k] = '0;
            end
            default: ;
         endcase
      end
      if (cmd.scan) begin
         if (hit) buf_in[pos_ff[IW-1:0]] = scan_e;
         pos_in = pos_nx;
         if (sc_ff == IW'(DEPTH - 1)) begin
            sc_in          = '0;
            end_in[seg_ff] = pos_nx;
            seg_in         = seg_ff + 2'd1;
         end else begin
            sc_in = sc_ff + IW'(1);
         end
      end
      if (cmd.seg_start) i_in = lo;
      if (cmd.next_seg) seg_in = seg_ff + 2'd1;
      if (cmd.row_start) begin
         best_in = buf_ff[i_ff[IW-1:0]];
         pick_in = i_ff[IW-1:0];
         j_in    = i_ff + CW'(1);
      end
      if (cmd.cmp) begin
         if (better) begin
            best_in = cand;
            pick_in = j_ff[IW-1:0];
         end
         j_in = j_ff + CW'(1);
      end
      if (cmd.swap) begin
         buf_in[pick_ff]         = buf_ff[i_ff[IW-1:0]];
         buf_in[i_ff[IW-1:0]]    = best_ff;
         i_in                    = i_ff + CW'(1);
      end
      if (cmd.copy) begin
         for (int k = 0; k < DEPTH; k++) begin
            if (CW'(k) < pos_ff) q_in[k] = buf_ff[k];
         end
         q_in[DEPTH-1] = '0;
         cnt_in        = '0;
      end
      if (cmd.dump_next) cnt_in = cnt_ff + IW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) q_ff[k] <= '0;
      end else begin
         q_ff <= q_in;
      end
      buf_ff  <= buf_in;
      end_ff  <= end_in;
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      new_ff  <= new_in;
      cf_ff   <= cf_in;
      dir_ff  <= dir_in;
      at_ff   <= at_in;
      rel_ff  <= rel_in;
      seg_ff  <= seg_in;
      sc_ff   <= sc_in;
      pos_ff  <= pos_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      pick_ff <= pick_in;
      best_ff <= best_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      status.regroup   = (dir_ff == DIR_UP) || (dir_ff == DIR_DOWN);
      status.is_add    = (op_ff == OP_ADD);
      status.scan_last = (sc_ff == IW'(DEPTH - 1)) && (seg_ff == 2'd3);
      status.row_done  = ({1'b0, i_ff} + (CW+1)'(1)) >= {1'b0, hi};
      status.seg_last  = (seg_ff == 2'd3);
      status.cmp_last  = ((j_ff + CW'(1)) == hi);
      status.dump_last = (cnt_ff == IW'(DEPTH - 1));
   end

   always_comb begin
      rd              = q_ff[cnt_ff];
      rsp_slot        = 4'(cnt_ff);
      rsp_entry_valid = rd.valid;
      rsp_entry_floor = rd.valid ? rd.floor : 4'd0;
      rsp_entry_kind  = rd.valid ? rd.kind : 2'd0;
      rsp_last_slot   = (cnt_ff == IW'(DEPTH - 1));
   end

endmodule

`default_nettype wire

/* src/eoqs_ctrl.sv */
// ----------------------------------------------------------------------------
// eoqs_ctrl
// Sequencer for operation apply, group scan, per-group selection sort,
// write-back and queue dump.
// ----------------------------------------------------------------------------
`default_nettype none

module eoqs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output eoqs_pkg::cmd_type        cmd,
   input  wire eoqs_pkg::status_type status
);
   import eoqs_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_APPLY = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_SEG   = 4'd3;
   localparam logic [3:0] ST_ROW   = 4'd4;
   localparam logic [3:0] ST_CMP   = 4'd5;
   localparam logic [3:0] ST_SWAP  = 4'd6;
   localparam logic [3:0] ST_COPY  = 4'd7;
   localparam logic [3:0] ST_DUMP  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (status.is_add) state_in = status.regroup ? ST_SCAN : ST_COPY;
            else state_in = ST_DUMP;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = ST_SEG;
         end
         ST_SEG: begin
            cmd.seg_start = 1'b1;
            state_in      = ST_ROW;
         end
         ST_ROW: begin
            if (status.row_done) begin
               if (status.seg_last) begin
                  state_in = ST_COPY;
               end else begin
                  cmd.next_seg = 1'b1;
                  state_in     = ST_SEG;
               end
            end else begin
               cmd.row_start = 1'b1;
               state_in      = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
            if (status.cmp_last) state_in = ST_SWAP;
         end
         ST_SWAP: begin
            cmd.swap = 1'b1;
            state_in = ST_ROW;
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            state_in = ST_DUMP;
         end
         ST_DUMP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.dump_last) state_in = ST_IDLE;
               else cmd.dump_next = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

/* src/elevator_order_queue_sorter.sv */
// Sequence: delete, clear and unknown opcodes go from apply straight to the dump; an add
// with direction stopped or unknown goes through apply and copy. An add with regroup scans
// every slot once per group, selection-sorts each group (row, compare, swap), then copies.
// Throughput: one operation at a time; QUEUE_DEPTH beats per operation, the
// dump paced by rsp_ready. For an add with regroup, the scan and sort loop set the rate.
// Reset: synchronous, empties the queue and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// elevator_order_queue_sorter
// Elevator order queue: add with direction-aware regroup and sort, delete
// with shift, clear, and a full queue dump after each operation.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_order_queue_sorter #(
   parameter int QUEUE_DEPTH = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [3:0]  req_slot_index,
   input  wire logic [3:0]  req_order_floor,
   input  wire logic [1:0]  req_order_kind,
   input  wire logic [3:0]  req_car_floor,
   input  wire logic [1:0]  req_direction,
   input  wire logic        req_at_floor,
   input  wire logic        req_relative_position,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_slot,
   output logic             rsp_entry_valid,
   output logic [3:0]       rsp_entry_floor,
   output logic [1:0]       rsp_entry_kind,
   output logic             rsp_last_slot
);
   import eoqs_pkg::*;

   cmd_type    cmd;
   status_type status;

   eoqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   eoqs_dpath #(.DEPTH(QUEUE_DEPTH)) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_opcode            (req_opcode),
      .req_slot_index        (req_slot_index),
      .req_order_floor       (req_order_floor),
      .req_order_kind        (req_order_kind),
      .req_car_floor         (req_car_floor),
      .req_direction         (req_direction),
      .req_at_floor          (req_at_floor),
      .req_relative_position (req_relative_position),
      .rsp_slot              (rsp_slot),
      .rsp_entry_valid       (rsp_entry_valid),
      .rsp_entry_floor       (rsp_entry_floor),
      .rsp_entry_kind        (rsp_entry_kind),
      .rsp_last_slot         (rsp_last_slot)
   );

endmodule

`default_nettype wire

/* sim/tb_elevator_order_queue_sorter.sv */
// ----------------------------------------------------------------------------
// tb_elevator_order_queue_sorter
// Self-checking bench for the elevator order queue sorter. A directed table
// covers reset, extremes, stopped and unknown directions, odd kinds, bad
// delete slots and unknown opcodes. Random order traffic follows. Every
// dumped beat is compared with a behavioral model of the queue, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_elevator_order_queue_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   import eoqs_pkg::*;

   localparam int QD          = 12;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_RANDOM  = 440;

   localparam logic [1:0] OP_NONE   = 2'd3;
   localparam logic [1:0] DIR_STOP  = 2'd2;
   localparam logic [1:0] DIR_NONE  = 2'd3;
   localparam logic [1:0] KIND_NONE = 2'd3;

   typedef struct {
      logic [1:0] op;
      logic [3:0] idx;
      logic [3:0] fl;
      logic [1:0] kd;
      logic [3:0] cf;
      logic [1:0] dir;
      logic       at;
      logic       rel;
      bit         empty_dump;
   } order_req_type;

   typedef struct packed {
      logic [3:0] slot;
      logic       valid;
      logic [3:0] floor;
      logic [1:0] kind;
      logic       last;
   } dump_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = '0;
   logic [3:0] req_slot_index = '0;
   logic [3:0] req_order_floor = '0;
   logic [1:0] req_order_kind = '0;
   logic [3:0] req_car_floor = '0;
   logic [1:0] req_direction = '0;
   logic       req_at_floor = 1'b0;
   logic       req_relative_position = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_slot;
   logic       rsp_entry_valid;
   logic [3:0] rsp_entry_floor;
   logic [1:0] rsp_entry_kind;
   logic       rsp_last_slot;

   entry_type     queue_model[QD];
   dump_beat_type dump_q[$];
   bit            empty_flag_q[$];
   bit            failed = 1'b0;
   bit            fast_mode = 1'b0;
   bit            hold_rsp = 1'b0;
   int            cycles = 0;
   order_req_type dir_rows[22];

   elevator_order_queue_sorter #(.QUEUE_DEPTH(QD)) dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int group_of(logic [3:0] fl, logic [1:0] k, logic [3:0] cf,
                                   logic [1:0] dir, logic at, logic rel);
      if (dir == DIR_UP) begin
         if (k == KIND_DOWN) return GRP_DOWN;
         if (at) begin
            if (k == KIND_CAB) return (fl >= cf) ? GRP_UP : GRP_DOWN;
            if (k == KIND_UP) return (fl >= cf) ? GRP_UP : GRP_SUP;
         end else begin
            if (k == KIND_CAB) return (fl > cf) ? GRP_UP : GRP_DOWN;
            if (k == KIND_UP) return (fl > cf || (!rel && fl == cf)) ? GRP_UP : GRP_SUP;
         end
      end else if (dir == DIR_DOWN) begin
         if (k == KIND_UP) return GRP_UP;
         if (at) begin
            if (k == KIND_CAB) return (fl <= cf) ? GRP_DOWN : GRP_UP;
            if (k == KIND_DOWN) return (fl <= cf) ? GRP_DOWN : GRP_SDOWN;
         end else begin
            if (k == KIND_CAB) return (fl < cf) ? GRP_DOWN : GRP_UP;
            if (k == KIND_DOWN) return (fl < cf || (rel && fl == cf)) ? GRP_DOWN : GRP_SDOWN;
         end
      end
      return GRP_NONE;
   endfunction

   function automatic void sort_floors(inout entry_type a[QD], input bit asc);
      int        pick;
      entry_type best;
      for (int i = 0; i < QD; i++) begin
         pick = i;
         best = a[i];
         for (int j = i; j < QD; j++) begin
            if (a[j].valid && (asc ? (a[j].floor < best.floor) : (a[j].floor > best.floor))) begin
               best = a[j];
               pick = j;
            end
         end
         a[pick] = a[i];
         a[i] = best;
      end
   endfunction

   function automatic void apply_order(order_req_type r, bit empty_dump);
      entry_type     grp[4][QD];
      entry_type     tmp[QD];
      int            cnt[4];
      int            seq[4];
      int            pos;
      int            g;
      dump_beat_type b;
      if (r.op == OP_ADD) begin
         queue_model[QD-1] = '{valid: 1'b1, floor: r.fl, kind: r.kd};
         if (r.dir == DIR_UP || r.dir == DIR_DOWN) begin
            for (int s = 0; s < 4; s++) begin
               cnt[s] = 0;
               for (int i = 0; i < QD; i++) grp[s][i] = '0;
            end
            for (int i = 0; i < QD; i++) begin
               if (queue_model[i].valid) begin
                  g = group_of(queue_model[i].floor, queue_model[i].kind, r.cf, r.dir,
                               r.at, r.rel);
                  if (g != GRP_NONE) begin
                     grp[g][cnt[g]] = queue_model[i];
                     cnt[g]++;
                  end
               end
            end
            for (int s = 0; s < 4; s++) begin
               tmp = grp[s];
               sort_floors(tmp, s == GRP_UP || s == GRP_SUP);
               grp[s] = tmp;
            end
            if (r.dir == DIR_UP) seq = '{GRP_UP, GRP_DOWN, GRP_SUP, GRP_SDOWN};
            else seq = '{GRP_DOWN, GRP_UP, GRP_SDOWN, GRP_SUP};
            pos = 0;
            for (int s = 0; s < 4; s++)
               for (int k = 0; k < cnt[seq[s]] && pos < QD; k++) begin
                  queue_model[pos] = grp[seq[s]][k];
                  pos++;
               end
         end
         queue_model[QD-1] = '0;
      end else if (r.op == OP_DEL) begin
         if (r.idx < QD) begin
            for (int j = r.idx; j + 1 < QD; j++) queue_model[j] = queue_model[j+1];
            queue_model[QD-1] = '0;
         end
      end else if (r.op == OP_CLR) begin
         for (int i = 0; i < QD; i++) queue_model[i] = '0;
      end
      for (int i = 0; i < QD; i++) begin
         b.slot  = i[3:0];
         b.valid = empty_dump ? 1'b0 : queue_model[i].valid;
         b.floor = (empty_dump || !queue_model[i].valid) ? 4'd0 : queue_model[i].floor;
         b.kind  = (empty_dump || !queue_model[i].valid) ? 2'd0 : queue_model[i].kind;
         b.last  = (i == QD - 1);
         dump_q.push_back(b);
      end
   endfunction

   always @(posedge clock) begin
      dump_beat_type e;
      if (!reset) begin
         if (req_valid && req_ready)
            apply_order('{req_opcode, req_slot_index, req_order_floor, req_order_kind,
                          req_car_floor, req_direction, req_at_floor,
                          req_relative_position, 1'b0}, empty_flag_q.pop_front());
         if (rsp_valid && rsp_ready) begin
            if (dump_q.size() == 0) begin
               $error("unexpected beat slot %0d", rsp_slot);
               failed = 1'b1;
            end else begin
               e = dump_q.pop_front();
               if (rsp_slot !== e.slot) begin
                  $error("slot exp %0d got %0d", e.slot, rsp_slot);
                  failed = 1'b1;
               end
               if (rsp_entry_valid !== e.valid) begin
                  $error("entry_valid exp %0d got %0d", e.valid, rsp_entry_valid);
                  failed = 1'b1;
               end
               if (rsp_entry_floor !== e.floor) begin
                  $error("entry_floor exp %0d got %0d", e.floor, rsp_entry_floor);
                  failed = 1'b1;
               end
               if (rsp_entry_kind !== e.kind) begin
                  $error("entry_kind exp %0d got %0d", e.kind, rsp_entry_kind);
                  failed = 1'b1;
               end
               if (rsp_last_slot !== e.last) begin
                  $error("last_slot exp %0d got %0d", e.last, rsp_last_slot);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // receiver: random stalls per beat, one long hold-off on request
   initial begin
      int w;
      @(negedge reset);
      forever begin
         w = fast_mode ? 0 : $urandom_range(0, 15);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            w = 400;
         end
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_order(order_req_type r);
      int gap;
      gap = fast_mode ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      empty_flag_q.push_back(r.empty_dump);
      req_valid             <= 1'b1;
      req_opcode            <= r.op;
      req_slot_index        <= r.idx;
      req_order_floor       <= r.fl;
      req_order_kind        <= r.kd;
      req_car_floor         <= r.cf;
      req_direction         <= r.dir;
      req_at_floor          <= r.at;
      req_relative_position <= r.rel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic order_req_type random_order();
      order_req_type r;
      int            p;
      p = $urandom_range(0, 99);
      r.op  = (p < 62) ? OP_ADD : (p < 88) ? OP_DEL : (p < 96) ? OP_CLR : OP_NONE;
      r.idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                          : 4'($urandom_range(0, 11));
      r.fl  = 4'($urandom);
      r.kd  = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
      r.cf  = 4'($urandom);
      r.dir = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                          : 2'($urandom_range(0, 1));
      r.at  = 1'($urandom);
      r.rel = 1'($urandom);
      r.empty_dump = 1'b0;
      return r;
   endfunction

   initial begin
      dir_rows = '{
         '{OP_CLR,  4'd0,  4'd0,  KIND_UP,   4'd0,  DIR_UP,   1'b0, 1'b0, 1'b1},
         '{OP_DEL,  4'd15, 4'd0,  KIND_UP,   4'd0,  DIR_UP,   1'b0, 1'b0, 1'b1},
         '{OP_NONE, 4'd0,  4'd15, KIND_CAB,  4'd15, DIR_DOWN, 1'b1, 1'b1, 1'b1},
         '{OP_ADD,  4'd0,  4'd15, KIND_CAB,  4'd3,  DIR_STOP, 1'b1, 1'b0, 1'b1},
         '{OP_ADD,  4'd0,  4'd7,  KIND_UP,   4'd3,  DIR_NONE, 1'b0, 1'b1, 1'b1},
         '{OP_ADD,  4'd0,  4'd15, KIND_UP,   4'd0,  DIR_UP,   1'b1, 1'b0, 1'b0},
         '{OP_ADD,  4'd0,  4'd0,  KIND_UP,   4'd5,  DIR_UP,   1'b1, 1'b0, 1'b0},
         '{OP_ADD,  4'd0,  4'd5,  KIND_UP,   4'd5,  DIR_UP,   1'b0, 1'b0, 1'b0},
         '{OP_ADD,  4'd0,  4'd5,  KIND_UP,   4'd5,  DIR_UP,   1'b0, 1'b1, 1'b0},
         '{OP_ADD,  4'd0,  4'd2,  KIND_CAB,  4'd5,  DIR_UP,   1'b0, 1'b0, 1'b0},
         '{OP_ADD,  4'd0,  4'd9,  KIND_DOWN, 4'd5,  DIR_UP,   1'b1, 1'b0, 1'b0},
         '{OP_ADD,  4'd0,  4'd6,  KIND_DOWN, 4'd6,  DIR_DOWN, 1'b0, 1'b1, 1'b0},
         '{OP_ADD,  4'd0,  4'd6,  KIND_DOWN, 4'd6,  DIR_DOWN, 1'b0, 1'b0, 1'b0},
         '{OP_ADD,  4'd0,  4'd12, KIND_DOWN, 4'd6,  DIR_DOWN, 1'b1, 1'b0, 1'b0},
         '{OP_ADD,  4'd0,  4'd1,  KIND_CAB,  4'd6,  DIR_DOWN, 1'b1, 1'b1, 1'b0},
         '{OP_ADD,  4'd0,  4'd8,  KIND_NONE, 4'd6,  DIR_DOWN, 1'b1, 1'b1, 1'b0},
         '{OP_ADD,  4'd0,  4'd4,  KIND_UP,   4'd6,  DIR_UP,   1'b0, 1'b1, 1'b0},
         '{OP_DEL,  4'd0,  4'd0,  KIND_UP,   4'd0,  DIR_UP,   1'b0, 1'b0, 1'b0},
         '{OP_DEL,  4'd11, 4'd0,  KIND_UP,   4'd0,  DIR_UP,   1'b0, 1'b0, 1'b0},
         '{OP_DEL,  4'd12, 4'd0,  KIND_UP,   4'd0,  DIR_UP,   1'b0, 1'b0, 1'b0},
         '{OP_DEL,  4'd2,  4'd0,  KIND_UP,   4'd0,  DIR_UP,   1'b0, 1'b0, 1'b0},
         '{OP_CLR,  4'd0,  4'd0,  KIND_UP,   4'd0,  DIR_UP,   1'b0, 1'b0, 1'b1}
      };
      for (int i = 0; i < QD; i++) queue_model[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_order(dir_rows[i]);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 150) hold_rsp = 1'b1;
         fast_mode = (n >= 150 && n < 165) || (n >= 220 && n < 270);
         if (n == 320) begin
            req_valid <= 1'b0;
            while (dump_q.size() != 0) @(posedge clock);
         end
         send_order(random_order());
      end
      req_valid <= 1'b0;
      fast_mode = 1'b0;
      while (dump_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (!failed && dump_q.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
